// ===== src/xcc_pkg.sv =====
`timescale 1ns / 1ps
package xcc_pkg;

    localparam int CpW = 21;

    typedef logic [CpW-1:0] cp_t;

    typedef struct packed {
        logic [15:0] lo;
        logic [15:0] hi;
    } range_t;

    typedef struct packed {
        logic is_char;
        logic is_ideographic;
        logic is_punct;
        logic is_pubid_char;
        logic is_white_space;
    } raw_flags_t;

    typedef struct packed {
        logic is_char;
        logic is_base_char;
        logic is_ideographic;
        logic is_letter;
        logic is_digit;
        logic is_combining;
        logic is_extender;
        logic is_name_char;
        logic is_pubid_char;
        logic is_white_space;
    } flags_t;

    localparam int NumBase = 201;
    localparam range_t BASE_TAB [NumBase] = '{
        '{16'h0041,16'h005A},'{16'h0061,16'h007A},'{16'h00C0,16'h00D6},'{16'h00D8,16'h00F6},
        '{16'h00F8,16'h00FF},'{16'h0100,16'h0131},'{16'h0134,16'h013E},'{16'h0141,16'h0148},
        '{16'h014A,16'h017E},'{16'h0180,16'h01C3},'{16'h01CD,16'h01F0},'{16'h01F4,16'h01F5},
        '{16'h01FA,16'h0217},'{16'h0250,16'h02A8},'{16'h02BB,16'h02C1},'{16'h0386,16'h0386},
        '{16'h0388,16'h038A},'{16'h038C,16'h038C},'{16'h038E,16'h03A1},'{16'h03A3,16'h03CE},
        '{16'h03D0,16'h03D6},'{16'h03DA,16'h03DA},'{16'h03DC,16'h03DC},'{16'h03DE,16'h03DE},
        '{16'h03E0,16'h03E0},'{16'h03E2,16'h03F3},'{16'h0401,16'h040C},'{16'h040E,16'h044F},
        '{16'h0451,16'h045C},'{16'h045E,16'h0481},'{16'h0490,16'h04C4},'{16'h04C7,16'h04C8},
        '{16'h04CB,16'h04CC},'{16'h04D0,16'h04EB},'{16'h04EE,16'h04F5},'{16'h04F8,16'h04F9},
        '{16'h0531,16'h0556},'{16'h0559,16'h0559},'{16'h0561,16'h0586},'{16'h05D0,16'h05EA},
        '{16'h05F0,16'h05F2},'{16'h0621,16'h063A},'{16'h0641,16'h064A},'{16'h0671,16'h06B7},
        '{16'h06BA,16'h06BE},'{16'h06C0,16'h06CE},'{16'h06D0,16'h06D3},'{16'h06D5,16'h06D5},
        '{16'h06E5,16'h06E6},'{16'h0905,16'h0939},'{16'h093D,16'h093D},'{16'h0958,16'h0961},
        '{16'h0985,16'h098C},'{16'h098F,16'h0990},'{16'h0993,16'h09A8},'{16'h09AA,16'h09B0},
        '{16'h09B2,16'h09B2},'{16'h09B6,16'h09B9},'{16'h09DC,16'h09DD},'{16'h09DF,16'h09E1},
        '{16'h09F0,16'h09F1},'{16'h0A05,16'h0A0A},'{16'h0A0F,16'h0A10},'{16'h0A13,16'h0A28},
        '{16'h0A2A,16'h0A30},'{16'h0A32,16'h0A33},'{16'h0A35,16'h0A36},'{16'h0A38,16'h0A39},
        '{16'h0A59,16'h0A5C},'{16'h0A5E,16'h0A5E},'{16'h0A72,16'h0A74},'{16'h0A85,16'h0A8B},
        '{16'h0A8D,16'h0A8D},'{16'h0A8F,16'h0A91},'{16'h0A93,16'h0AA8},'{16'h0AAA,16'h0AB0},
        '{16'h0AB2,16'h0AB3},'{16'h0AB5,16'h0AB9},'{16'h0ABD,16'h0ABD},'{16'h0AE0,16'h0AE0},
        '{16'h0B05,16'h0B0C},'{16'h0B0F,16'h0B10},'{16'h0B13,16'h0B28},'{16'h0B2A,16'h0B30},
        '{16'h0B32,16'h0B33},'{16'h0B36,16'h0B39},'{16'h0B3D,16'h0B3D},'{16'h0B5C,16'h0B5D},
        '{16'h0B5F,16'h0B61},'{16'h0B85,16'h0B8A},'{16'h0B8E,16'h0B90},'{16'h0B92,16'h0B95},
        '{16'h0B99,16'h0B9A},'{16'h0B9C,16'h0B9C},'{16'h0B9E,16'h0B9F},'{16'h0BA3,16'h0BA4},
        '{16'h0BA8,16'h0BAA},'{16'h0BAE,16'h0BB5},'{16'h0BB7,16'h0BB9},'{16'h0C05,16'h0C0C},
        '{16'h0C0E,16'h0C10},'{16'h0C12,16'h0C28},'{16'h0C2A,16'h0C33},'{16'h0C35,16'h0C39},
        '{16'h0C60,16'h0C61},'{16'h0C85,16'h0C8C},'{16'h0C8E,16'h0C90},'{16'h0C92,16'h0CA8},
        '{16'h0CAA,16'h0CB3},'{16'h0CB5,16'h0CB9},'{16'h0CDE,16'h0CDE},'{16'h0CE0,16'h0CE1},
        '{16'h0D05,16'h0D0C},'{16'h0D0E,16'h0D10},'{16'h0D12,16'h0D28},'{16'h0D2A,16'h0D39},
        '{16'h0D60,16'h0D61},'{16'h0E01,16'h0E2E},'{16'h0E30,16'h0E30},'{16'h0E32,16'h0E33},
        '{16'h0E40,16'h0E45},'{16'h0E81,16'h0E82},'{16'h0E84,16'h0E84},'{16'h0E87,16'h0E88},
        '{16'h0E8A,16'h0E8A},'{16'h0E8D,16'h0E8D},'{16'h0E94,16'h0E97},'{16'h0E99,16'h0E9F},
        '{16'h0EA1,16'h0EA3},'{16'h0EA5,16'h0EA5},'{16'h0EA7,16'h0EA7},'{16'h0EAA,16'h0EAB},
        '{16'h0EAD,16'h0EAE},'{16'h0EB0,16'h0EB0},'{16'h0EB2,16'h0EB3},'{16'h0EBD,16'h0EBD},
        '{16'h0EC0,16'h0EC4},'{16'h0F40,16'h0F47},'{16'h0F49,16'h0F69},'{16'h10A0,16'h10C5},
        '{16'h10D0,16'h10F6},'{16'h1100,16'h1100},'{16'h1102,16'h1103},'{16'h1105,16'h1107},
        '{16'h1109,16'h1109},'{16'h110B,16'h110C},'{16'h110E,16'h1112},'{16'h113C,16'h113C},
        '{16'h113E,16'h113E},'{16'h1140,16'h1140},'{16'h114C,16'h114C},'{16'h114E,16'h114E},
        '{16'h1154,16'h1155},'{16'h1159,16'h1159},'{16'h115F,16'h1161},'{16'h1163,16'h1163},
        '{16'h1165,16'h1165},'{16'h1167,16'h1167},'{16'h1169,16'h1169},'{16'h116D,16'h116E},
        '{16'h1172,16'h1173},'{16'h1175,16'h1175},'{16'h119E,16'h119E},'{16'h11A8,16'h11A8},
        '{16'h11AB,16'h11AB},'{16'h11AE,16'h11AF},'{16'h11B7,16'h11B8},'{16'h11BA,16'h11BA},
        '{16'h11BC,16'h11C2},'{16'h11EB,16'h11EB},'{16'h11F0,16'h11F0},'{16'h11F9,16'h11F9},
        '{16'h1E00,16'h1E9B},'{16'h1EA0,16'h1EF9},'{16'h1F00,16'h1F15},'{16'h1F18,16'h1F1D},
        '{16'h1F20,16'h1F45},'{16'h1F48,16'h1F4D},'{16'h1F50,16'h1F57},'{16'h1F59,16'h1F59},
        '{16'h1F5B,16'h1F5B},'{16'h1F5D,16'h1F5D},'{16'h1F5F,16'h1F7D},'{16'h1F80,16'h1FB4},
        '{16'h1FB6,16'h1FBC},'{16'h1FBE,16'h1FBE},'{16'h1FC2,16'h1FC4},'{16'h1FC6,16'h1FCC},
        '{16'h1FD0,16'h1FD3},'{16'h1FD6,16'h1FDB},'{16'h1FE0,16'h1FEC},'{16'h1FF2,16'h1FF4},
        '{16'h1FF6,16'h1FFC},'{16'h2126,16'h2126},'{16'h212A,16'h212B},'{16'h212E,16'h212E},
        '{16'h2180,16'h2182},'{16'h3041,16'h3094},'{16'h30A1,16'h30FA},'{16'h3105,16'h312C},
        '{16'hAC00,16'hD7A3}
    };

    localparam int NumComb = 95;
    localparam range_t COMB_TAB [NumComb] = '{
        '{16'h0300,16'h0345},'{16'h0360,16'h0361},'{16'h0483,16'h0486},'{16'h0591,16'h05A1},
        '{16'h05A3,16'h05B9},'{16'h05BB,16'h05BD},'{16'h05BF,16'h05BF},'{16'h05C1,16'h05C2},
        '{16'h05C4,16'h05C4},'{16'h064B,16'h0652},'{16'h0670,16'h0670},'{16'h06D6,16'h06DC},
        '{16'h06DD,16'h06DF},'{16'h06E0,16'h06E4},'{16'h06E7,16'h06E8},'{16'h06EA,16'h06ED},
        '{16'h0901,16'h0903},'{16'h093C,16'h093C},'{16'h093E,16'h094C},'{16'h094D,16'h094D},
        '{16'h0951,16'h0954},'{16'h0962,16'h0963},'{16'h0981,16'h0983},'{16'h09BC,16'h09BC},
        '{16'h09BE,16'h09BE},'{16'h09BF,16'h09BF},'{16'h09C0,16'h09C4},'{16'h09C7,16'h09C8},
        '{16'h09CB,16'h09CD},'{16'h09D7,16'h09D7},'{16'h09E2,16'h09E3},'{16'h0A02,16'h0A02},
        '{16'h0A3C,16'h0A3C},'{16'h0A3E,16'h0A3E},'{16'h0A3F,16'h0A3F},'{16'h0A40,16'h0A42},
        '{16'h0A47,16'h0A48},'{16'h0A4B,16'h0A4D},'{16'h0A70,16'h0A71},'{16'h0A81,16'h0A83},
        '{16'h0ABC,16'h0ABC},'{16'h0ABE,16'h0AC5},'{16'h0AC7,16'h0AC9},'{16'h0ACB,16'h0ACD},
        '{16'h0B01,16'h0B03},'{16'h0B3C,16'h0B3C},'{16'h0B3E,16'h0B43},'{16'h0B47,16'h0B48},
        '{16'h0B4B,16'h0B4D},'{16'h0B56,16'h0B57},'{16'h0B82,16'h0B83},'{16'h0BBE,16'h0BC2},
        '{16'h0BC6,16'h0BC8},'{16'h0BCA,16'h0BCD},'{16'h0BD7,16'h0BD7},'{16'h0C01,16'h0C03},
        '{16'h0C3E,16'h0C44},'{16'h0C46,16'h0C48},'{16'h0C4A,16'h0C4D},'{16'h0C55,16'h0C56},
        '{16'h0C82,16'h0C83},'{16'h0CBE,16'h0CC4},'{16'h0CC6,16'h0CC8},'{16'h0CCA,16'h0CCD},
        '{16'h0CD5,16'h0CD6},'{16'h0D02,16'h0D03},'{16'h0D3E,16'h0D43},'{16'h0D46,16'h0D48},
        '{16'h0D4A,16'h0D4D},'{16'h0D57,16'h0D57},'{16'h0E31,16'h0E31},'{16'h0E34,16'h0E3A},
        '{16'h0E47,16'h0E4E},'{16'h0EB1,16'h0EB1},'{16'h0EB4,16'h0EB9},'{16'h0EBB,16'h0EBC},
        '{16'h0EC8,16'h0ECD},'{16'h0F18,16'h0F19},'{16'h0F35,16'h0F35},'{16'h0F37,16'h0F37},
        '{16'h0F39,16'h0F39},'{16'h0F3E,16'h0F3E},'{16'h0F3F,16'h0F3F},'{16'h0F71,16'h0F84},
        '{16'h0F86,16'h0F8B},'{16'h0F90,16'h0F95},'{16'h0F97,16'h0F97},'{16'h0F99,16'h0FAD},
        '{16'h0FB1,16'h0FB7},'{16'h0FB9,16'h0FB9},'{16'h20D0,16'h20DC},'{16'h20E1,16'h20E1},
        '{16'h302A,16'h302F},'{16'h3099,16'h3099},'{16'h309A,16'h309A}
    };

    localparam int NumDigit = 15;
    localparam range_t DIGIT_TAB [NumDigit] = '{
        '{16'h0030,16'h0039},'{16'h0660,16'h0669},'{16'h06F0,16'h06F9},'{16'h0966,16'h096F},
        '{16'h09E6,16'h09EF},'{16'h0A66,16'h0A6F},'{16'h0AE6,16'h0AEF},'{16'h0B66,16'h0B6F},
        '{16'h0BE7,16'h0BEF},'{16'h0C66,16'h0C6F},'{16'h0CE6,16'h0CEF},'{16'h0D66,16'h0D6F},
        '{16'h0E50,16'h0E59},'{16'h0ED0,16'h0ED9},'{16'h0F20,16'h0F29}
    };

    localparam int NumExt = 11;
    localparam range_t EXT_TAB [NumExt] = '{
        '{16'h00B7,16'h00B7},'{16'h02D0,16'h02D0},'{16'h02D1,16'h02D1},'{16'h0387,16'h0387},
        '{16'h0640,16'h0640},'{16'h0E46,16'h0E46},'{16'h0EC6,16'h0EC6},'{16'h3005,16'h3005},
        '{16'h3031,16'h3035},'{16'h309D,16'h309E},'{16'h30FC,16'h30FE}
    };

    // Hit vector widths, one bit per range after the compare stage.
    localparam int HitW = NumBase + NumComb + NumDigit + NumExt;

endpackage

// ===== src/xcc_compare.sv =====
`timescale 1ns / 1ps
// Stage 1: one pair of compares per table range, plus the simple classes.
module xcc_compare
    import xcc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 en,
    input  cp_t                  code_point,
    output logic [NumBase-1:0]   base_hit_reg,
    output logic [NumComb-1:0]   comb_hit_reg,
    output logic [NumDigit-1:0]  digit_hit_reg,
    output logic [NumExt-1:0]    ext_hit_reg,
    output raw_flags_t           simple_reg
);

    logic [NumBase-1:0]  base_hit_next;
    logic [NumComb-1:0]  comb_hit_next;
    logic [NumDigit-1:0] digit_hit_next;
    logic [NumExt-1:0]   ext_hit_next;
    raw_flags_t          simple_next;
    logic                bmp;
    logic [15:0]         lo16;
    logic [7:0]          c8;

    assign bmp  = (code_point[20:16] == 5'd0);
    assign lo16 = code_point[15:0];
    assign c8   = code_point[7:0];

    always_comb begin
        for (int i = 0; i < NumBase; i++)
            base_hit_next[i] = bmp && lo16 >= BASE_TAB[i].lo && lo16 <= BASE_TAB[i].hi;
        for (int i = 0; i < NumComb; i++)
            comb_hit_next[i] = bmp && lo16 >= COMB_TAB[i].lo && lo16 <= COMB_TAB[i].hi;
        for (int i = 0; i < NumDigit; i++)
            digit_hit_next[i] = bmp && lo16 >= DIGIT_TAB[i].lo && lo16 <= DIGIT_TAB[i].hi;
        for (int i = 0; i < NumExt; i++)
            ext_hit_next[i] = bmp && lo16 >= EXT_TAB[i].lo && lo16 <= EXT_TAB[i].hi;

        simple_next = '0;
        simple_next.is_char = (code_point == 21'h9) || (code_point == 21'hA)
            || (code_point == 21'hD)
            || (code_point >= 21'h20 && code_point <= 21'hD7FF)
            || (code_point >= 21'hE000 && code_point <= 21'hFFFD)
            || (code_point >= 21'h10000 && code_point <= 21'h10FFFF);
        simple_next.is_ideographic = (code_point == 21'h3007)
            || (code_point >= 21'h3021 && code_point <= 21'h3029)
            || (code_point >= 21'h4E00 && code_point <= 21'h9FA5);
        simple_next.is_white_space = (code_point == 21'h20) || (code_point == 21'h9)
            || (code_point == 21'hA) || (code_point == 21'hD);
        simple_next.is_punct = (code_point == 21'h2E) || (code_point == 21'h2D)
            || (code_point == 21'h5F) || (code_point == 21'h3A);
        if (code_point[20:8] == 13'd0) begin
            if ((c8 >= 8'h61 && c8 <= 8'h7A) || (c8 >= 8'h41 && c8 <= 8'h5A)
                || (c8 >= 8'h30 && c8 <= 8'h39))
                simple_next.is_pubid_char = 1'b1;
            case (c8)
                8'h20, 8'h0D, 8'h0A, 8'h2D, 8'h27, 8'h28, 8'h29, 8'h2B, 8'h2C,
                8'h2E, 8'h2F, 8'h3A, 8'h3D, 8'h3F, 8'h3B, 8'h21, 8'h2A, 8'h23,
                8'h40, 8'h24, 8'h5F, 8'h25: simple_next.is_pubid_char = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            base_hit_reg  <= base_hit_next;
            comb_hit_reg  <= comb_hit_next;
            digit_hit_reg <= digit_hit_next;
            ext_hit_reg   <= ext_hit_next;
            simple_reg    <= simple_next;
        end
    end

endmodule

// ===== src/xcc_reduce.sv =====
`timescale 1ns / 1ps
// Stages 2 and 3: OR the hit vectors in groups of 16, then finish the classes.
module xcc_reduce
    import xcc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 en2,
    input  logic                 en3,
    input  logic [NumBase-1:0]   base_hit,
    input  logic [NumComb-1:0]   comb_hit,
    input  logic [NumDigit-1:0]  digit_hit,
    input  logic [NumExt-1:0]    ext_hit,
    input  raw_flags_t           simple,
    output flags_t               flags_reg
);

    localparam int Grp    = 16;
    localparam int BaseG  = (NumBase + Grp - 1) / Grp;
    localparam int CombG  = (NumComb + Grp - 1) / Grp;

    logic [BaseG-1:0] base_part_reg, base_part_next;
    logic [CombG-1:0] comb_part_reg, comb_part_next;
    logic             digit_reg, ext_reg;
    raw_flags_t       simple2_reg;
    flags_t           flags_next;
    logic             base, comb;

    always_comb begin
        base_part_next = '0;
        comb_part_next = '0;
        for (int i = 0; i < NumBase; i++)
            base_part_next[i / Grp] = base_part_next[i / Grp] | base_hit[i];
        for (int i = 0; i < NumComb; i++)
            comb_part_next[i / Grp] = comb_part_next[i / Grp] | comb_hit[i];
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            base_part_reg <= base_part_next;
            comb_part_reg <= comb_part_next;
            digit_reg     <= |digit_hit;
            ext_reg       <= |ext_hit;
            simple2_reg   <= simple;
        end
    end

    always_comb begin
        base = |base_part_reg;
        comb = |comb_part_reg;
        flags_next.is_char        = simple2_reg.is_char;
        flags_next.is_base_char   = base;
        flags_next.is_ideographic = simple2_reg.is_ideographic;
        flags_next.is_letter      = base | simple2_reg.is_ideographic;
        flags_next.is_digit       = digit_reg;
        flags_next.is_combining   = comb;
        flags_next.is_extender    = ext_reg;
        flags_next.is_name_char   = base | simple2_reg.is_ideographic | digit_reg | comb
            | ext_reg | simple2_reg.is_punct;
        flags_next.is_pubid_char  = simple2_reg.is_pubid_char;
        flags_next.is_white_space = simple2_reg.is_white_space;
    end

    always_ff @(posedge aclk) begin
        if (en3)
            flags_reg <= flags_next;
    end

endmodule

// ===== src/xml_character_classifier_core.sv =====
`timescale 1ns / 1ps
// XML 1.0 character classifier. Each code point gets ten class flags at once.
// Throughput is one item per cycle while m_ready stays high. The pipeline has
// three register stages: range compares, a grouped OR tree, and the final class
// merge into the output register. m_valid is the valid bit v3_reg, which follows
// the item through v1_reg and v2_reg after the edge that accepts it.
// Stalls hold each valid stage whose successor cannot advance; a stage with no
// valid item always loads.
module xml_character_classifier_core
    import xcc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cp_t      s_code_point,
    output logic     m_valid,
    input  logic     m_ready,
    output logic     m_is_char,
    output logic     m_is_base_char,
    output logic     m_is_ideographic,
    output logic     m_is_letter,
    output logic     m_is_digit,
    output logic     m_is_combining,
    output logic     m_is_extender,
    output logic     m_is_name_char,
    output logic     m_is_pubid_char,
    output logic     m_is_white_space
);

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    logic [NumBase-1:0]  base_hit;
    logic [NumComb-1:0]  comb_hit;
    logic [NumDigit-1:0] digit_hit;
    logic [NumExt-1:0]   ext_hit;
    raw_flags_t          simple;
    flags_t              flags;

    // Advance a stage when it is empty or its successor moves.
    assign en3     = !v3_reg || m_ready;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    xcc_compare u_compare (
        .aclk          (aclk),
        .en            (en1),
        .code_point    (s_code_point),
        .base_hit_reg  (base_hit),
        .comb_hit_reg  (comb_hit),
        .digit_hit_reg (digit_hit),
        .ext_hit_reg   (ext_hit),
        .simple_reg    (simple)
    );

    xcc_reduce u_reduce (
        .aclk      (aclk),
        .en2       (en2),
        .en3       (en3),
        .base_hit  (base_hit),
        .comb_hit  (comb_hit),
        .digit_hit (digit_hit),
        .ext_hit   (ext_hit),
        .simple    (simple),
        .flags_reg (flags)
    );

    assign m_valid          = v3_reg;
    assign m_is_char        = flags.is_char;
    assign m_is_base_char   = flags.is_base_char;
    assign m_is_ideographic = flags.is_ideographic;
    assign m_is_letter      = flags.is_letter;
    assign m_is_digit       = flags.is_digit;
    assign m_is_combining   = flags.is_combining;
    assign m_is_extender    = flags.is_extender;
    assign m_is_name_char   = flags.is_name_char;
    assign m_is_pubid_char  = flags.is_pubid_char;
    assign m_is_white_space = flags.is_white_space;

endmodule

// ===== src/xcc_checker.sv =====
`timescale 1ns / 1ps
module xcc_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_is_letter,
    input logic m_is_base_char,
    input logic m_is_ideographic,
    input logic m_is_name_char,
    input logic m_is_digit,
    input logic m_is_char
);

    a_letter: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_letter == (m_is_base_char || m_is_ideographic)))
        else $error("letter flag mismatch");

    a_name: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_is_letter || m_is_digit) |-> m_is_name_char)
        else $error("name char flag missing");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_char))
        else $error("stalled item changed");

endmodule

bind xml_character_classifier_core xcc_checker u_xcc_checker (.*);
